/* sv/lesq_pkg.sv */
// ----------------------------------------------------------------------------
// lesq_pkg
// Shared constants and types for the largest empty square query block.
// ----------------------------------------------------------------------------
package lesq_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int CFG_W   = 7;   // rows_in_use / cols_in_use
  localparam int RC_W    = 6;   // row, col request fields
  localparam int SIDE_W  = 7;   // side, max_side
  localparam int IDX_W   = 12;  // obstacle_index
  localparam int CW      = 12;  // working width of row/col arithmetic
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_LARGEST = 2'd1;
  localparam logic [1:0] MODE_FIRST   = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [SIDE_W-1:0] max_side;
    logic              found;
    logic [IDX_W-1:0]  index;
  } res_t;

  typedef struct packed {
    logic          hit;
    logic [CW-1:0] pos;
  } row_stat_t;

endpackage

/* sv/lesq_ram.sv */
// ----------------------------------------------------------------------------
// lesq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lesq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lesq_row_unit.sv */
// ----------------------------------------------------------------------------
// lesq_row_unit
// Shared row unit: aligns a map row to the anchor column, folds it into the
// running AND, and finds the first obstacle inside the examined width.
// ----------------------------------------------------------------------------
module lesq_row_unit import lesq_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic [MAX_COLS-1:0] row_data,
  input  logic [MAX_COLS-1:0] acc_in,
  input  logic [CW-1:0]       col,
  input  logic [CW-1:0]       width,
  output logic [MAX_COLS-1:0] acc_out,
  output row_stat_t           stat
);

  logic [MAX_COLS-1:0] shifted;
  logic [MAX_COLS-1:0] mask;
  logic [MAX_COLS-1:0] miss;

  always_comb begin
    shifted = row_data >> col;
    acc_out = acc_in & shifted;
    for (int i = 0; i < MAX_COLS; i++) begin
      mask[i] = (CW'(i) < width);
    end
    miss     = ~acc_out & mask;
    stat.hit = |miss;
    stat.pos = '0;
    for (int i = MAX_COLS - 1; i >= 0; i--) begin
      if (miss[i]) begin
        stat.pos = CW'(i);
      end
    end
  end

endmodule

/* sv/lesq_seq.sv */
// ----------------------------------------------------------------------------
// lesq_seq
// Request sequencer: clears the map after reset, performs cell writes as
// read-modify-write, and walks the map one row per cycle through the row
// unit for square and obstacle queries.
// ----------------------------------------------------------------------------
module lesq_seq import lesq_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  logic [RC_W-1:0]   row,
  input  logic [RC_W-1:0]   col,
  input  logic              cell_empty,
  input  logic [SIDE_W-1:0] side,
  input  logic [CW-1:0]     nr,
  input  logic [CW-1:0]     nc,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  localparam int RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CA = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef enum logic [7:0] {
    S_CLR   = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_WR_RD = 8'b0000_0100,
    S_WR    = 8'b0000_1000,
    S_RD    = 8'b0001_0000,
    S_EV    = 8'b0010_0000,
    S_IDX   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [RA-1:0]       clr_cnt;
  logic [1:0]          mode_q;
  logic                cell_q;
  logic [CW-1:0]       c_q;
  logic [CW-1:0]       cur_row;
  logic [CW-1:0]       s_cnt;
  logic [CW-1:0]       lim;
  logic [CW-1:0]       width_q;
  logic [CW-1:0]       hit_col;
  logic [MAX_COLS-1:0] acc;
  res_t                res_q;

  logic [CW-1:0]       r_in, c_in, side_in;
  logic [CW-1:0]       rsum, csum, rend_in, cend_in;
  logic [CW-1:0]       row_inc;
  logic                largest;

  logic                we;
  logic [RA-1:0]       waddr, raddr;
  logic [MAX_COLS-1:0] wdata, rd_data, wr_row;

  logic [CW-1:0]       u_width;
  logic [MAX_COLS-1:0] u_acc_in, u_acc_out;
  row_stat_t           u_stat;

  assign r_in    = CW'(row);
  assign c_in    = CW'(col);
  assign side_in = CW'(side);
  assign rsum    = r_in + side_in;
  assign csum    = c_in + side_in;
  assign rend_in = (rsum > nr) ? nr : rsum;
  assign cend_in = (csum > nc) ? nc : csum;
  assign row_inc = cur_row + CW'(1);
  assign largest = (mode_q == MODE_LARGEST);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_q;

  lesq_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign u_width  = largest ? s_cnt : width_q;
  assign u_acc_in = largest ? acc : '1;

  lesq_row_unit #(
    .MAX_COLS (MAX_COLS)
  ) u_row (
    .row_data (rd_data),
    .acc_in   (u_acc_in),
    .col      (c_q),
    .width    (u_width),
    .acc_out  (u_acc_out),
    .stat     (u_stat)
  );

  always_comb begin
    wr_row = rd_data;
    wr_row[c_q[CA-1:0]] = cell_q;
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt;
    wdata = '0;
    raddr = cur_row[RA-1:0];
    unique case (state)
      S_CLR: begin
        we = 1'b1;
      end
      S_WR: begin
        we    = 1'b1;
        waddr = cur_row[RA-1:0];
        wdata = wr_row;
      end
      S_EV: begin
        raddr = row_inc[RA-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (clr_cnt == RA'(MAX_ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (mode)
            MODE_WRITE: begin
              state_next = (r_in < CW'(MAX_ROWS) && c_in < CW'(MAX_COLS)) ? S_WR_RD : S_DONE;
            end
            MODE_LARGEST: begin
              state_next = (r_in < nr && c_in < nc) ? S_RD : S_DONE;
            end
            MODE_FIRST: begin
              state_next = (r_in < rend_in && c_in < cend_in) ? S_RD : S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_WR_RD: state_next = S_WR;
      S_WR:    state_next = S_DONE;
      S_RD:    state_next = S_EV;
      S_EV: begin
        if (largest) begin
          if (u_stat.hit || !(row_inc < nr && c_q + s_cnt < nc)) begin
            state_next = S_DONE;
          end
        end else if (u_stat.hit) begin
          state_next = S_IDX;
        end else if (!(row_inc < lim)) begin
          state_next = S_DONE;
        end
      end
      S_IDX: state_next = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        clr_cnt <= clr_cnt + RA'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          mode_q  <= mode;
          cell_q  <= cell_empty;
          c_q     <= c_in;
          cur_row <= r_in;
          s_cnt   <= CW'(1);
          lim     <= rend_in;
          width_q <= cend_in - c_in;
          acc     <= '1;
          res_q   <= '0;
        end
      end
      S_EV: begin
        if (largest) begin
          if (!u_stat.hit) begin
            res_q.max_side <= s_cnt[SIDE_W-1:0];
            acc            <= u_acc_out;
            cur_row        <= row_inc;
            s_cnt          <= s_cnt + CW'(1);
          end
        end else if (u_stat.hit) begin
          hit_col <= c_q + u_stat.pos;
        end else begin
          cur_row <= row_inc;
        end
      end
      S_IDX: begin
        res_q.found <= 1'b1;
        res_q.index <= IDX_W'(cur_row * nc + hit_col);
      end
      default: ;
    endcase
  end

endmodule

/* sv/largest_empty_square_query.sv */
// Sequence: a cell write reads its row, then writes it back; a square query
//   reads map rows in turn, and an obstacle query adds an index step on a hit.
// Throughput: one request at a time, one map row per cycle through the shared
//   row unit and the single read port of the map RAM.
// Reset: registers return to 64/64 and a clearing pass writes every map row
//   to obstacle; no request is taken during it.
// ----------------------------------------------------------------------------
// largest_empty_square_query
// Binary map with cell writes, largest empty square and first obstacle
// queries; APB register port and registered result output.
// ----------------------------------------------------------------------------
module largest_empty_square_query import lesq_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [RC_W-1:0]    row,
  input  logic [RC_W-1:0]    col,
  input  logic               cell_empty,
  input  logic [SIDE_W-1:0]  side,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SIDE_W-1:0]  max_side,
  output logic               obstacle_found,
  output logic [IDX_W-1:0]   obstacle_index
);

  logic [CFG_W-1:0] rows_in_use;
  logic [CFG_W-1:0] cols_in_use;
  logic [CW-1:0]    nr, nc;
  logic             res_valid, res_ready;
  res_t             res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CFG_W'(64);
      cols_in_use <= CFG_W'(64);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_ROWS: rows_in_use <= pwdata[CFG_W-1:0];
        REG_COLS: cols_in_use <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROWS: prdata = PDATA_W'(rows_in_use);
      REG_COLS: prdata = PDATA_W'(cols_in_use);
      default:  prdata = '0;
    endcase
  end

  assign nr = (CW'(rows_in_use) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(rows_in_use);
  assign nc = (CW'(cols_in_use) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_in_use);

  lesq_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .row        (row),
    .col        (col),
    .cell_empty (cell_empty),
    .side       (side),
    .nr         (nr),
    .nc         (nc),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      max_side       <= res.max_side;
      obstacle_found <= res.found;
      obstacle_index <= res.index;
    end
  end

endmodule
